>>> design/wcs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wcs_pkg
// Constants shared by the wavelet coefficient shrinkage block.
// ----------------------------------------------------------------------------
package wcs_pkg;

  localparam int unsigned FracBits  = 16;
  localparam int unsigned LamWidth  = 31;
  localparam int unsigned ShapeWidth = 21;
  localparam int unsigned CfgWidth  = 31;

  localparam logic [ShapeWidth-1:0] ShapeMin = 21'd131073;
  localparam logic [ShapeWidth-1:0] OneQ16   = 21'd65536;
  localparam logic [ShapeWidth-1:0] TwoQ16   = 21'd131072;

  typedef enum logic [1:0] {
    RegRuleMode  = 2'd0,
    RegThreshold = 2'd1,
    RegScadShape = 2'd2,
    RegNone      = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    RuleHard     = 2'd0,
    RuleSoft     = 2'd1,
    RuleSemisoft = 2'd2,
    RuleScad     = 2'd3
  } rule_e;

endpackage
`default_nettype wire

>>> design/wavelet_coefficient_shrinkage.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wavelet_coefficient_shrinkage
// Hard, soft, semisoft hyperbolic and SCAD shrinkage of Q15.16 coefficients.
// ----------------------------------------------------------------------------
// Fully pipelined: one coefficient is accepted per cycle while the output is
// not stalled. The square root and divider work one bit per stage and both run
// over max(COEFF_WIDTH,32)+1 stages after the sign/magnitude and partial-product
// stages. The pipeline advances as a whole; it holds while a result is waiting
// on a stalled output. Configuration must be written by the user only while
// the pipeline is empty; the block itself does not enforce this.
module wavelet_coefficient_shrinkage #(
  parameter int unsigned COEFF_WIDTH = 32
) (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       cfg_we_i,
  input  wire [1:0]                 cfg_idx_i,
  input  wire [wcs_pkg::CfgWidth-1:0] cfg_data_i,
  input  wire                       in_valid_i,
  output logic                      in_stall_o,
  input  wire [COEFF_WIDTH-1:0]     coeff_in_i,
  output logic                      out_valid_o,
  input  wire                       out_stall_i,
  output logic [COEFF_WIDTH-1:0]    coeff_out_o
);

  localparam int unsigned CW  = COEFF_WIDTH;
  localparam int unsigned MW  = (CW > 32) ? CW : 32;
  localparam int unsigned PW  = MW + 1;
  localparam int unsigned HW  = (PW + 1) / 2;
  localparam int unsigned NW  = 4 * HW;
  localparam int unsigned RW  = PW;
  localparam int unsigned SW  = wcs_pkg::ShapeWidth;
  localparam int unsigned LW  = wcs_pkg::LamWidth;
  localparam int unsigned DW  = SW;
  localparam int unsigned DNW = RW + DW;
  localparam int unsigned AW  = SW + 2 * HW;
  localparam int unsigned XW  = MW + SW + wcs_pkg::FracBits;

  // configuration
  logic [1:0]    mode_q;
  logic [LW-1:0] lam_q;
  logic [SW-1:0] shape_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= wcs_pkg::RuleSoft;
      lam_q   <= 31'd65536;
      shape_q <= 21'd242483;
    end else if (cfg_we_i) begin
      unique case (wcs_pkg::reg_idx_e'(cfg_idx_i))
        wcs_pkg::RegRuleMode:  mode_q  <= cfg_data_i[1:0];
        wcs_pkg::RegThreshold: lam_q   <= cfg_data_i[LW-1:0];
        wcs_pkg::RegScadShape: shape_q <= cfg_data_i[SW-1:0];
        default: ;
      endcase
    end
  end

  logic [SW-1:0] a_eff, am1, dvs;
  logic [MW-1:0] lam_m;
  assign a_eff = (shape_q < wcs_pkg::ShapeMin) ? wcs_pkg::ShapeMin : shape_q;
  assign am1   = a_eff - wcs_pkg::OneQ16;
  assign dvs   = a_eff - wcs_pkg::TwoQ16;
  assign lam_m = MW'(lam_q);

  // global advance
  logic en;
  logic out_valid_q;
  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  // stage A: sign and magnitude
  logic          va_q, nega_q;
  logic [MW-1:0] maga_q;
  logic [CW-1:0] mag_raw;
  assign mag_raw = coeff_in_i[CW-1] ? (CW'(0) - coeff_in_i) : coeff_in_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (en) begin
      va_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      nega_q <= coeff_in_i[CW-1];
      maga_q <= MW'(mag_raw);
    end
  end

  // stage B: partial products
  logic [2*HW-1:0] p_b, q_b, mag_b;
  logic            ge_b;
  assign ge_b  = maga_q >= lam_m;
  assign p_b   = ge_b ? (2*HW)'(maga_q - lam_m) : '0;
  assign q_b   = (2*HW)'(maga_q) + (2*HW)'(lam_m);
  assign mag_b = (2*HW)'(maga_q);

  logic            vb_q, negb_q, geb_q;
  logic [MW-1:0]   magb_q;
  logic [2*HW-1:0] pp_hh_q, pp_hl_q, pp_lh_q, pp_ll_q;
  logic [SW+HW-1:0] am_hi_q, am_lo_q;
  logic [SW+LW-1:0] alam_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else if (en) begin
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      negb_q  <= nega_q;
      geb_q   <= ge_b;
      magb_q  <= maga_q;
      pp_hh_q <= p_b[2*HW-1:HW] * q_b[2*HW-1:HW];
      pp_hl_q <= p_b[2*HW-1:HW] * q_b[HW-1:0];
      pp_lh_q <= p_b[HW-1:0] * q_b[2*HW-1:HW];
      pp_ll_q <= p_b[HW-1:0] * q_b[HW-1:0];
      am_hi_q <= am1 * mag_b[2*HW-1:HW];
      am_lo_q <= am1 * mag_b[HW-1:0];
      alam_q  <= a_eff * lam_q;
    end
  end

  // stage C: sums, region select, seed of the iterative stages
  logic [NW-1:0]  n_c;
  logic [AW-1:0]  amm_c;
  logic [DNW-1:0] num_c;
  logic [XW-1:0]  mag_x, lam_x, lam2_x, magsh_x, alam_x;
  logic [MW-1:0]  simple_c;
  logic           sqrt_c, div_c;

  always_comb begin
    n_c = (NW'(pp_hh_q) << (2*HW)) + (NW'(pp_hl_q) << HW) + (NW'(pp_lh_q) << HW)
        + NW'(pp_ll_q);
    amm_c   = (AW'(am_hi_q) << HW) + AW'(am_lo_q);
    num_c   = DNW'(amm_c - AW'(alam_q));
    mag_x   = XW'(magb_q);
    lam_x   = XW'(lam_q);
    lam2_x  = lam_x << 1;
    magsh_x = mag_x << wcs_pkg::FracBits;
    alam_x  = XW'(alam_q);
    simple_c = '0;
    sqrt_c   = 1'b0;
    div_c    = 1'b0;
    unique case (wcs_pkg::rule_e'(mode_q))
      wcs_pkg::RuleHard:     simple_c = geb_q ? magb_q : '0;
      wcs_pkg::RuleSoft:     simple_c = geb_q ? (magb_q - lam_m) : '0;
      wcs_pkg::RuleSemisoft: sqrt_c   = geb_q;
      wcs_pkg::RuleScad: begin
        priority if (mag_x <= lam_x) begin
          simple_c = '0;
        end else if (mag_x <= lam2_x) begin
          simple_c = magb_q - lam_m;
        end else if (magsh_x <= alam_x) begin
          div_c = 1'b1;
        end else begin
          simple_c = magb_q;
        end
      end
      default: ;
    endcase
  end

  // iterative stages: one root bit and one quotient bit per stage
  logic            v_q     [RW+1];
  logic            neg_q   [RW+1];
  logic            usq_q   [RW+1];
  logic            udv_q   [RW+1];
  logic [MW-1:0]   smp_q   [RW+1];
  logic [NW-1:0]   n_q     [RW+1];
  logic [RW+1:0]   rem_q   [RW+1];
  logic [RW-1:0]   root_q  [RW+1];
  logic [RW-1:0]   dlo_q   [RW+1];
  logic [DW-1:0]   drem_q  [RW+1];
  logic [RW-1:0]   quo_q   [RW+1];

  logic [NW-1:0]   n_d     [RW+1];
  logic [RW+1:0]   rem_d   [RW+1];
  logic [RW-1:0]   root_d  [RW+1];
  logic [RW-1:0]   dlo_d   [RW+1];
  logic [DW-1:0]   drem_d  [RW+1];
  logic [RW-1:0]   quo_d   [RW+1];

  always_comb begin
    logic [RW+1:0] t;
    logic [RW+1:0] trial;
    logic [DW:0]   dt;
    n_d[0]    = NW'(n_c) << (NW - 2*RW);
    rem_d[0]  = '0;
    root_d[0] = '0;
    dlo_d[0]  = num_c[RW-1:0];
    drem_d[0] = num_c[DNW-1:RW];
    quo_d[0]  = '0;
    for (int k = 0; k < RW; k++) begin
      t     = {rem_q[k][RW-1:0], n_q[k][NW-1:NW-2]};
      trial = {root_q[k], 2'b01};
      if (t >= trial) begin
        rem_d[k+1]  = t - trial;
        root_d[k+1] = {root_q[k][RW-2:0], 1'b1};
      end else begin
        rem_d[k+1]  = t;
        root_d[k+1] = {root_q[k][RW-2:0], 1'b0};
      end
      n_d[k+1] = n_q[k] << 2;
      dt = {drem_q[k], dlo_q[k][RW-1]};
      if (dt >= (DW+1)'(dvs)) begin
        drem_d[k+1] = DW'(dt - (DW+1)'(dvs));
        quo_d[k+1]  = {quo_q[k][RW-2:0], 1'b1};
      end else begin
        drem_d[k+1] = DW'(dt);
        quo_d[k+1]  = {quo_q[k][RW-2:0], 1'b0};
      end
      dlo_d[k+1] = dlo_q[k] << 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= RW; k++) v_q[k] <= 1'b0;
    end else if (en) begin
      v_q[0] <= vb_q;
      for (int k = 0; k < RW; k++) v_q[k+1] <= v_q[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      neg_q[0] <= negb_q;
      usq_q[0] <= sqrt_c;
      udv_q[0] <= div_c;
      smp_q[0] <= simple_c;
      for (int k = 0; k < RW; k++) begin
        neg_q[k+1] <= neg_q[k];
        usq_q[k+1] <= usq_q[k];
        udv_q[k+1] <= udv_q[k];
        smp_q[k+1] <= smp_q[k];
      end
      for (int k = 0; k <= RW; k++) begin
        n_q[k]    <= n_d[k];
        rem_q[k]  <= rem_d[k];
        root_q[k] <= root_d[k];
        dlo_q[k]  <= dlo_d[k];
        drem_q[k] <= drem_d[k];
        quo_q[k]  <= quo_d[k];
      end
    end
  end

  // output register
  logic [MW-1:0] res_f;
  logic [CW-1:0] out_d;
  logic [CW-1:0] coeff_out_q;
  always_comb begin
    priority if (usq_q[RW]) begin
      res_f = MW'(root_q[RW]);
    end else if (udv_q[RW]) begin
      res_f = MW'(quo_q[RW]);
    end else begin
      res_f = smp_q[RW];
    end
    out_d = neg_q[RW] ? (CW'(0) - res_f[CW-1:0]) : res_f[CW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= v_q[RW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      coeff_out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign coeff_out_o = coeff_out_q;

endmodule
`default_nettype wire

>>> tb/wavelet_coefficient_shrinkage_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wavelet_coefficient_shrinkage_tb
// Streams signed Q15.16 coefficients through the shrinkage block under hard,
// soft, semisoft and SCAD settings, including threshold and shape extremes.
// A scoreboard works out each shrunk value and checks results in order,
// with random idle cycles on the input and random stalls on the output.
// ----------------------------------------------------------------------------
module wavelet_coefficient_shrinkage_tb;

  localparam int unsigned CW        = 32;
  localparam int unsigned DrainWait = 60;
  localparam int unsigned StuckMax  = 4000;

  class shrink_ledger;
    wcs_pkg::rule_e mode;
    logic [30:0]  lam;
    logic [20:0]  shape;
    logic [CW-1:0] pending_q[$];
    int unsigned  errors;

    function new();
      mode   = wcs_pkg::RuleSoft;
      lam    = 31'd65536;
      shape  = 21'd242483;
      errors = 0;
    endfunction

    function logic [CW-1:0] shrink(logic [CW-1:0] x);
      logic         neg;
      logic [CW-1:0] nx;
      logic [63:0]  mag, l, res, a, alam, num, r, c;
      logic [127:0] prod, sq;
      neg = x[CW-1];
      nx  = -x;
      mag = neg ? 64'(nx) : 64'(x);
      l   = 64'(lam);
      res = '0;
      case (mode)
        wcs_pkg::RuleHard: res = (mag >= l) ? mag : '0;
        wcs_pkg::RuleSoft: res = (mag >= l) ? mag - l : '0;
        wcs_pkg::RuleSemisoft: begin
          if (mag >= l) begin
            prod = 128'(mag - l) * 128'(mag + l);
            r = '0;
            for (int b = 50; b >= 0; b--) begin
              c  = r | (64'd1 << b);
              sq = 128'(c) * 128'(c);
              if (sq <= prod) r = c;
            end
            res = r;
          end
        end
        default: begin
          a = (shape < wcs_pkg::ShapeMin) ? 64'(wcs_pkg::ShapeMin) : 64'(shape);
          alam = a * l;
          if (mag <= l) res = '0;
          else if (mag <= 2 * l) res = mag - l;
          else if ((mag << wcs_pkg::FracBits) <= alam) begin
            num = (a - 64'(wcs_pkg::OneQ16)) * mag - alam;
            res = num / (a - 64'(wcs_pkg::TwoQ16));
          end else res = mag;
        end
      endcase
      return neg ? -res[CW-1:0] : res[CW-1:0];
    endfunction

    function void note_coeff(logic [CW-1:0] x);
      pending_q.push_back(shrink(x));
    endfunction

    function void check_coeff(logic [CW-1:0] y);
      logic [CW-1:0] want;
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", y);
        return;
      end
      want = pending_q.pop_front();
      if (want !== y) begin
        errors++;
        if (errors <= 10) $display("coeff_out mismatch: expected %h got %h", want, y);
      end
    endfunction
  endclass

  logic          clk_i, rst_ni;
  logic          cfg_we_i;
  wcs_pkg::reg_idx_e cfg_idx_i;
  logic [wcs_pkg::CfgWidth-1:0] cfg_data_i;
  logic          in_valid_i, in_stall_o;
  logic [CW-1:0] coeff_in_i;
  logic          out_valid_o, out_stall_i;
  logic [CW-1:0] coeff_out_o;

  shrink_ledger ledger = new();
  int unsigned  send_idle_pct, recv_stall_pct, stuck;

  wavelet_coefficient_shrinkage #(.COEFF_WIDTH(CW)) DUT (.*);

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = wcs_pkg::RegRuleMode;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    coeff_in_i  = '0;
    out_stall_i = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // output side: random stall, result check, stuck-run watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) ledger.check_coeff(coeff_out_o);
      if ((out_valid_o && !out_stall_i) || (in_valid_i && !in_stall_o)) stuck <= 0;
      else if (stuck >= StuckMax) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else stuck <= stuck + 1;
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end else stuck <= 0;
  end

  task automatic send_coeff(logic [CW-1:0] x);
    in_valid_i <= 1'b1;
    coeff_in_i <= x;
    do @(posedge clk_i); while (in_stall_o);
    ledger.note_coeff(x);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (ledger.pending_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic write_reg(wcs_pkg::reg_idx_e idx, logic [wcs_pkg::CfgWidth-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      wcs_pkg::RegRuleMode:  ledger.mode  = wcs_pkg::rule_e'(val[1:0]);
      wcs_pkg::RegThreshold: ledger.lam   = val[30:0];
      wcs_pkg::RegScadShape: ledger.shape = val[20:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic apply_setting(wcs_pkg::rule_e m, logic [30:0] l,
                               logic [wcs_pkg::CfgWidth-1:0] s);
    write_reg(wcs_pkg::RegRuleMode, wcs_pkg::CfgWidth'(m));
    write_reg(wcs_pkg::RegThreshold, wcs_pkg::CfgWidth'(l));
    write_reg(wcs_pkg::RegScadShape, s);
  endtask

  function automatic logic [CW-1:0] pick_coeff();
    logic [63:0] m, l, a;
    int unsigned k;
    l = 64'(ledger.lam);
    a = (ledger.shape < wcs_pkg::ShapeMin) ? 64'(wcs_pkg::ShapeMin) : 64'(ledger.shape);
    k = $urandom_range(5);
    case (k)
      0: return CW'($urandom);
      1: m = l + $urandom_range(6) - 3;
      2: m = 2 * l + $urandom_range(6) - 3;
      3: m = ((a * l) >> wcs_pkg::FracBits) + $urandom_range(6) - 3;
      4: m = 64'($urandom_range(0, 200000));
      default: m = (64'($urandom) * ((a * l) >> wcs_pkg::FracBits)) >> 31;
    endcase
    if (m > 64'h8000_0000) m = 64'h8000_0000;
    return $urandom_range(1) ? -m[CW-1:0] : m[CW-1:0];
  endfunction

  logic [CW-1:0] edge_vals[12] = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
      32'h8000_0000, 32'd65535, 32'd65536, 32'd65537, -32'd65536, 32'd131072,
      32'd242483, -32'd200000};

  initial begin
    send_idle_pct  = 20;
    recv_stall_pct = 63;
    @(posedge rst_ni);
    @(posedge clk_i);

    for (int m = 0; m < 4; m++) begin
      write_reg(wcs_pkg::RegRuleMode, wcs_pkg::CfgWidth'(m));
      for (int i = 0; i < 6; i++) send_coeff(edge_vals[(m * 3 + i) % 12]);
      drain();
    end

    for (int s = 0; s < 12; s++) begin
      if (s == 4) begin
        send_idle_pct  = 63;
        recv_stall_pct = 20;
      end else if (s == 8) begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      case (s)
        0:  apply_setting(wcs_pkg::RuleHard, 31'd65536, 31'd242483);
        1:  apply_setting(wcs_pkg::RuleSoft, 31'd0, 31'd242483);
        2:  apply_setting(wcs_pkg::RuleSemisoft, 31'h7FFF_FFFF, 31'd242483);
        3:  apply_setting(wcs_pkg::RuleScad, 31'd100000, 31'd0);
        4:  apply_setting(wcs_pkg::RuleScad, 31'd3000000, 31'd131073);
        5:  apply_setting(wcs_pkg::RuleScad, 31'h7FFF_FFFF, 31'd1048576);
        6:  apply_setting(wcs_pkg::RuleSemisoft, 31'd196608, 31'd242483);
        7:  apply_setting(wcs_pkg::RuleSoft, 31'h7FFF_FFFF, 31'd242483);
        8:  apply_setting(wcs_pkg::RuleHard, 31'd0, 31'd242483);
        9:  apply_setting(wcs_pkg::RuleScad, 31'd0, 31'h7FFF_FFFF);
        10: begin
          apply_setting(wcs_pkg::RuleScad, 31'd40000, 31'd242483);
          write_reg(wcs_pkg::RegNone, 31'h5A5A_5A5A);
        end
        default: apply_setting(wcs_pkg::RuleSemisoft, 31'd0, 31'd242483);
      endcase
      for (int i = 0; i < 78; i++) send_coeff(pick_coeff());
      drain();
    end

    if (ledger.errors == 0 && ledger.pending_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
